// ----- src/ssr_pkg.sv -----
// shared types and constants for the subset sum reachability block
`timescale 1ns / 1ps

package ssr_pkg;

    // fixed field widths
    localparam int WEIGHT_W = 16;
    localparam int SUM_W    = 6;

    // command queue depth between front and back
    localparam int Q_DEPTH = 2;

    typedef enum logic
    {
        OP_ADD  = 1'b0,
        OP_EMIT = 1'b1
    } op_t;

    typedef enum logic
    {
        ST_RUN  = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    // classified command handed from front to back
    typedef struct packed
    {
        op_t              op;
        logic             big;
        logic [SUM_W-1:0] weight;
    } cmd_t;

endpackage

// ----- src/ssr_front.sv -----
// front end: classifies incoming beats into queue commands
`timescale 1ns / 1ps

module ssr_front #(
    parameter int MAX_SUM = 63
) (
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         operation,
    input  logic [ssr_pkg::WEIGHT_W-1:0] weight,
    output logic                         push,
    output ssr_pkg::cmd_t                push_cmd,
    input  logic                         q_full
);

    logic big;

    // a weight past the limit cannot move any sum inside the map
    assign big = (weight > ssr_pkg::WEIGHT_W'(MAX_SUM));

    always_comb
    begin
        push_cmd.op     = ssr_pkg::op_t'(operation);
        push_cmd.big    = big;
        push_cmd.weight = big ? '0 : weight[ssr_pkg::SUM_W-1:0];
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

endmodule

// ----- src/ssr_queue.sv -----
// short command queue between front and back
`timescale 1ns / 1ps

module ssr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ssr_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output ssr_pkg::cmd_t q_cmd
);

    localparam int AW = (ssr_pkg::Q_DEPTH > 1) ? $clog2(ssr_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(ssr_pkg::Q_DEPTH + 1);

    ssr_pkg::cmd_t entry_reg [ssr_pkg::Q_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(ssr_pkg::Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(ssr_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(ssr_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/ssr_back.sv -----
// back end: bitmap update, emit walk and output register
`timescale 1ns / 1ps

module ssr_back #(
    parameter int MAX_SUM = 63
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  ssr_pkg::cmd_t             q_cmd,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [ssr_pkg::SUM_W-1:0] partial_sum,
    output logic                      truncated,
    output logic                      last
);

    localparam int MAP_W = MAX_SUM + 1;
    localparam int TOT_W = $clog2(MAX_SUM + 1);

    ssr_pkg::state_t state_reg;
    ssr_pkg::state_t state_next;

    logic [MAP_W-1:0]         reach_reg;
    logic [MAP_W-1:0]         reach_next;
    logic [TOT_W-1:0]         total_reg;
    logic [TOT_W-1:0]         total_next;
    logic                     ovf_reg;
    logic                     ovf_next;
    logic [MAP_W-1:0]         walk_reg;
    logic [MAP_W-1:0]         walk_next;
    logic                     trunc_reg;
    logic                     trunc_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [ssr_pkg::SUM_W-1:0] sum_reg;
    logic [ssr_pkg::SUM_W-1:0] sum_next;
    logic                     trunc_out_reg;
    logic                     trunc_out_next;
    logic                     last_reg;
    logic                     last_next;

    logic                     out_free;
    logic [TOT_W:0]           add_sum;
    logic [MAP_W-1:0]         walk_rest;
    logic [ssr_pkg::SUM_W-1:0] low_idx;

    assign out_free  = !out_valid_reg || !out_stall;
    assign add_sum   = (TOT_W + 1)'(total_reg) + (TOT_W + 1)'(q_cmd.weight);
    // drop the lowest set bit
    assign walk_rest = walk_reg & (walk_reg - 1'b1);

    // lowest set bit of the walk map
    always_comb
    begin
        low_idx = '0;
        for (int i = MAP_W - 1; i >= 0; i--)
        begin
            if (walk_reg[i])
            begin
                low_idx = ssr_pkg::SUM_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        reach_next     = reach_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        walk_next      = walk_reg;
        trunc_next     = trunc_reg;
        out_valid_next = out_valid_reg && out_stall;
        sum_next       = sum_reg;
        trunc_out_next = trunc_out_reg;
        last_next      = last_reg;
        pop            = 1'b0;

        case (state_reg)
            ssr_pkg::ST_RUN:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    if (q_cmd.op == ssr_pkg::OP_ADD)
                    begin
                        if (q_cmd.big || add_sum > (TOT_W + 1)'(MAX_SUM))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            total_next = add_sum[TOT_W-1:0];
                        end
                        reach_next = reach_reg | (reach_reg << q_cmd.weight);
                    end
                    else
                    begin
                        walk_next  = reach_reg;
                        trunc_next = ovf_reg;
                        reach_next = MAP_W'(1);
                        total_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ssr_pkg::ST_WALK;
                    end
                end
            end
            ssr_pkg::ST_WALK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    sum_next       = low_idx;
                    trunc_out_next = trunc_reg;
                    last_next      = (walk_rest == '0);
                    walk_next      = walk_rest;
                    if (walk_rest == '0)
                    begin
                        state_next = ssr_pkg::ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ssr_pkg::ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssr_pkg::ST_RUN;
            reach_reg     <= MAP_W'(1);
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            reach_reg     <= reach_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg      <= walk_next;
        trunc_reg     <= trunc_next;
        sum_reg       <= sum_next;
        trunc_out_reg <= trunc_out_next;
        last_reg      <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign partial_sum = sum_reg;
    assign truncated   = trunc_out_reg;
    assign last        = last_reg;

endmodule

// ----- src/subset_sum_reachability_top.sv -----
// subset sum reachability: top level
//
//   channel   dir   handshake            payload
//   in        in    in_valid/in_stall    operation, weight
//   out       out   out_valid/out_stall  partial_sum, truncated, last
//
// an add updates the map in the back end as it is popped; an emit snapshots
// the map, then the lowest bit walk feeds the output register one reachable
// sum per cycle while the output is not stalled.
// a two entry command queue takes input beats while an emit drains, until full.
// reset leaves only sum zero reachable and the overflow flag clear.
// out_stall holds the output register; the walk pauses until it frees.
`timescale 1ns / 1ps

module subset_sum_reachability_top #(
    parameter int MAX_SUM = 63
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         operation,
    input  logic [ssr_pkg::WEIGHT_W-1:0] weight,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ssr_pkg::SUM_W-1:0]    partial_sum,
    output logic                         truncated,
    output logic                         last
);

    logic          push;
    ssr_pkg::cmd_t push_cmd;
    logic          q_full;
    logic          pop;
    logic          q_valid;
    ssr_pkg::cmd_t q_cmd;

    ssr_front #(
        .MAX_SUM (MAX_SUM)
    ) u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .weight    (weight),
        .push      (push),
        .push_cmd  (push_cmd),
        .q_full    (q_full)
    );

    ssr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    ssr_back #(
        .MAX_SUM (MAX_SUM)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .partial_sum (partial_sum),
        .truncated   (truncated),
        .last        (last)
    );

endmodule
